// File: rtl/ddo_pkg.sv
// Package for the differential drive odometry block: constants, CORDIC angle table.
// No dependencies.
`default_nettype none
package ddo_pkg;
	localparam logic [31:0] PI_OVER_180_Q32 = 32'd74961321;
	localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [1:0] REG_INIT_HEADING = 2'd0;
	localparam logic [1:0] REG_WHEEL_RADIUS = 2'd1;
	localparam logic [1:0] REG_INV_TRACK    = 2'd2;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd536870912;
				5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;
				5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;
				5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;
				5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;
				5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;
				5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;
				5'd19: r = 32'd1304;
				5'd20: r = 32'd652;
				5'd21: r = 32'd326;
				5'd22: r = 32'd163;
				5'd23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

// File: rtl/ddo_serial_mul.sv
// Shift-add signed multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the odometry top level.
`default_nettype none
module ddo_serial_mul #(
	parameter int AW = 34,
	parameter int BW = 33
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [BW-1:0] b,
	output logic                      done,
	output logic signed [AW+BW-1:0]   p
);
	localparam int CW = $clog2(BW + 1);
	logic signed [AW+BW-1:0] acc_q;
	logic signed [AW+BW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q <= (AW+BW)'(a);
			b_q <= b;
		end else if (busy_q) begin
			// top bit of b has negative weight
			if (b_q[0]) begin
				if (cnt_q == CW'(BW - 1)) acc_q <= acc_q - a_q;
				else acc_q <= acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end
	assign p = acc_q;
endmodule
`default_nettype wire

// File: rtl/ddo_cordic.sv
// Iterative CORDIC rotation giving cosine and sine in Q4.30.
// Depends on ddo_pkg (angle table, gain).
`default_nettype none
module ddo_cordic import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [31:0]        angle,
	output logic                    done,
	output logic signed [33:0]      cos_o,
	output logic signed [33:0]      sin_o
);
	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic flip_q, busy_q;
	logic [4:0] i_q;
	logic flip;
	logic [31:0] ang;
	logic signed [33:0] xs, ys, at;

	assign flip = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
	assign ang = flip ? angle + 32'h8000_0000 : angle;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = 34'(atan_turn(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= 34'(CORDIC_GAIN_Q30);
			y_q <= '0;
			z_q <= 34'(signed'(ang));
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

// File: rtl/differential_drive_odometry.sv
// Top level of the differential drive odometry block: sequencer, state, output register.
// Depends on ddo_pkg, ddo_serial_mul, ddo_cordic.
//
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_ready  | action, left_angle, right_angle, pos_x, pos_y
// out     | out       | out_valid/out_ready| new_x, new_y, heading_out
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An update word runs 7 serial multiplies on the one shared bit-serial multiplier, plus
// the CORDIC, which overlaps the first product: out_valid rises once the last multiply
// is done and the result has passed through ST_OUT into the output register.
// A start word goes from ST_IDLE to ST_OUT, which loads the output register and sets out_valid.
// One word at a time; in_ready is low while a word is in work or its result waits.
// Reset clears stored angles and heading and loads register defaults.
`default_nettype none
module differential_drive_odometry import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int HEADING_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic signed [31:0] left_angle,
	input  wire logic signed [31:0] right_angle,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      new_x,
	output logic signed [31:0]      new_y,
	output logic [15:0]             heading_out,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);
	localparam int HB = HEADING_BITS;
	localparam int PW = 67;
	localparam logic [3:0] ST_IDLE = 4'd0, ST_SCALE = 4'd1, ST_UL = 4'd2, ST_UR = 4'd3,
		ST_MC = 4'd4, ST_MS = 4'd5, ST_W = 4'd6, ST_DH = 4'd7, ST_OUT = 4'd8;

	logic [3:0] st_q;
	logic [15:0] init_head_q, radius_q;
	logic [23:0] itw_q;
	logic signed [31:0] lprev_q, rprev_q;
	logic [HB-1:0] head_q;
	logic signed [31:0] la_q, ra_q, px_q, py_q;
	logic signed [33:0] scale_q, ul_q, ur_q, w_q, cos_q, sin_q;
	logic signed [31:0] nx_q, ny_q;

	logic mstart, mdone, cstart, cdone;
	logic signed [33:0] ma;
	logic signed [32:0] mb;
	logic signed [PW-1:0] mp;
	logic signed [33:0] ccos, csin;

	ddo_serial_mul #(.AW(34), .BW(33)) u_mul (.clk, .arst_n, .start(mstart), .a(ma),
		.b(mb), .done(mdone), .p(mp));
	ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (.clk, .arst_n, .start(cstart),
		.angle({head_q, {(32-HB){1'b0}}}), .done(cdone), .cos_o(ccos), .sin_o(csin));

	function automatic logic signed [31:0] sat(input logic signed [PW-1:0] v);
		if (v > PW'(64'sd2147483647)) return 32'sh7fffffff;
		if (v < -PW'(64'sd2147483648)) return 32'sh80000000;
		return v[31:0];
	endfunction

	// heading as 16 bits
	function automatic logic [15:0] to16(input logic [HB-1:0] h);
		logic [HB+23:0] t;
		t = {h, 24'd0};
		return t[HB+23 -: 16];
	endfunction

	logic signed [33:0] mean;
	logic signed [PW-1:0] rnd30, rnd24, rndh;
	assign mean = (ul_q + ur_q) >>> 1;
	assign rnd30 = (mp + (PW'(1) <<< 29)) >>> 30;
	assign rnd24 = (mp + (PW'(1) <<< 23)) >>> 24;
	assign rndh = (mp + (PW'(1) <<< (47 - HB))) >>> (48 - HB);

	assign in_ready = (st_q == ST_IDLE) && !out_valid;
	assign cfg_ready = 1'b1;
	assign cstart = (st_q == ST_IDLE) && in_valid && in_ready && !action;

	always_comb begin
		ma = '0; mb = '0;
		case (st_q)
			ST_SCALE: begin ma = 34'(radius_q); mb = 33'(PI_OVER_180_Q32); end
			ST_UL: begin ma = 34'(la_q) - 34'(lprev_q); mb = scale_q[32:0]; end
			ST_UR: begin ma = 34'(ra_q) - 34'(rprev_q); mb = scale_q[32:0]; end
			ST_MC: begin ma = cos_q; mb = mean[32:0]; end
			ST_MS: begin ma = sin_q; mb = mean[32:0]; end
			ST_W: begin ma = ur_q - ul_q; mb = 33'(itw_q); end
			ST_DH: begin ma = w_q; mb = 33'(INV_TWO_PI_Q32); end
			default: ;
		endcase
	end

	logic go_q;
	assign mstart = go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			go_q <= 1'b0;
			out_valid <= 1'b0;
			init_head_q <= 16'd32768;
			radius_q <= 16'd12800;
			itw_q <= 24'd111848;
			lprev_q <= '0;
			rprev_q <= '0;
			head_q <= '0;
		end else begin
			go_q <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_INIT_HEADING: init_head_q <= cfg_data[15:0];
					REG_WHEEL_RADIUS: radius_q <= cfg_data[15:0];
					REG_INV_TRACK: itw_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: if (in_valid && in_ready) begin
					la_q <= left_angle; ra_q <= right_angle;
					px_q <= pos_x; py_q <= pos_y;
					if (action) begin
						lprev_q <= left_angle; rprev_q <= right_angle;
						head_q <= HB'({init_head_q, 24'd0} >> (40 - HB));
						nx_q <= pos_x; ny_q <= pos_y;
						st_q <= ST_OUT;
					end else begin
						st_q <= ST_SCALE; go_q <= 1'b1;
					end
				end
				ST_SCALE: if (mdone) begin
					scale_q <= rnd24[33:0]; st_q <= ST_UL; go_q <= 1'b1;
				end
				ST_UL: if (mdone) begin
					ul_q <= 34'(sat(mp)); st_q <= ST_UR; go_q <= 1'b1;
				end
				ST_UR: if (mdone) begin
					ur_q <= 34'(sat(mp)); st_q <= ST_MC; go_q <= 1'b1;
				end
				ST_MC: if (mdone) begin
					nx_q <= sat(PW'(px_q) + rnd30); st_q <= ST_MS; go_q <= 1'b1;
				end
				ST_MS: if (mdone) begin
					ny_q <= sat(PW'(py_q) + rnd30); st_q <= ST_W; go_q <= 1'b1;
				end
				ST_W: if (mdone) begin
					w_q <= rnd24[33:0]; st_q <= ST_DH; go_q <= 1'b1;
				end
				ST_DH: if (mdone) begin
					head_q <= head_q + rndh[HB-1:0];
					lprev_q <= la_q; rprev_q <= ra_q;
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					new_x <= nx_q; new_y <= ny_q; heading_out <= to16(head_q);
					out_valid <= 1'b1; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// CORDIC finishes during the scale multiply, well before its results are used
	always_ff @(posedge clk) begin
		if (cdone) begin
			cos_q <= ccos; sin_q <= csin;
		end
	end
endmodule
`default_nettype wire
